[rtl/radix_conversion_stream_defines.svh]
// Assertion macros for the radix conversion stream block.
// Included by the top level only; depends on nothing else.
`ifndef RADIX_CONVERSION_STREAM_DEFINES_SVH
`define RADIX_CONVERSION_STREAM_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define RCS_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("radix conversion check failed");

// Next-cycle implication, checked outside reset
`define RCS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("radix conversion check failed");

`endif

[rtl/rcs_pkg.sv]
// Shared types, constants and digit helpers for the radix conversion stream.
// Used by the channel interfaces and the top level; depends on nothing.
package rcs_pkg;

  localparam int VALUE_BITS = 32;
  localparam int MAX_DIGITS = 32;
  localparam int BASE_W     = 6;
  localparam int CHAR_W     = 8;
  localparam int DIGIT_W    = 7;  // digit value plus the no-digit code
  localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
  localparam int IDX_W      = $clog2(MAX_DIGITS);
  localparam int BIT_CNT_W  = $clog2(VALUE_BITS);
  localparam int REG_IDX_W  = 1;

  localparam logic [BASE_W-1:0]  BASE_MIN      = 6'd2;
  localparam logic [BASE_W-1:0]  BASE_MAX      = 6'd36;
  localparam logic [BASE_W-1:0]  SRC_BASE_RST  = 6'd10;
  localparam logic [BASE_W-1:0]  TGT_BASE_RST  = 6'd2;
  localparam logic [BASE_W-1:0]  DEC_RADIX     = 6'd10;
  localparam logic [CHAR_W-1:0]  CHAR_ZERO     = 8'h30;
  localparam logic [CHAR_W-1:0]  CHAR_NINE     = 8'h39;
  localparam logic [CHAR_W-1:0]  CHAR_LOW_A    = 8'h61;
  localparam logic [CHAR_W-1:0]  CHAR_LOW_Z    = 8'h7a;
  localparam logic [DIGIT_W-1:0] NO_DIGIT      = 7'd64;

  // Register indexes on the configuration port
  localparam logic [REG_IDX_W-1:0] REG_SOURCE_BASE = 1'd0;
  localparam logic [REG_IDX_W-1:0] REG_TARGET_BASE = 1'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIVIDE,
    ST_READ,
    ST_LOAD,
    ST_SHOW
  } rcs_state_t;

  // Pin a base register into the legal radix range
  function automatic logic [BASE_W-1:0] clamp_base(input logic [BASE_W-1:0] b);
    logic [BASE_W-1:0] r;
    r = b;
    if (b < BASE_MIN) r = BASE_MIN;
    else if (b > BASE_MAX) r = BASE_MAX;
    return r;
  endfunction

  // Map an ASCII code to its digit value, NO_DIGIT when it is none
  function automatic logic [DIGIT_W-1:0] decode_char(input logic [CHAR_W-1:0] c);
    logic [DIGIT_W-1:0] d;
    d = NO_DIGIT;
    if (c >= CHAR_ZERO && c <= CHAR_NINE)
      d = DIGIT_W'(c - CHAR_ZERO);
    else if (c >= CHAR_LOW_A && c <= CHAR_LOW_Z)
      d = DIGIT_W'(c - CHAR_LOW_A) + DIGIT_W'(DEC_RADIX);
    return d;
  endfunction

  // Map a digit value below 36 to its lowercase ASCII code
  function automatic logic [CHAR_W-1:0] encode_digit(input logic [BASE_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DEC_RADIX) c = CHAR_ZERO + CHAR_W'(d);
    else               c = CHAR_LOW_A + CHAR_W'(d - DEC_RADIX);
    return c;
  endfunction

endpackage

[rtl/rcs_in_if.sv]
// Input channel: one ASCII character per beat with its end-of-number mark.
// Depends on rcs_pkg.
interface rcs_in_if;
  import rcs_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              final_char;

  modport source (output valid, char_code, final_char, input ready);
  modport sink   (input valid, char_code, final_char, output ready);
endinterface

[rtl/rcs_out_if.sv]
// Output channel: one converted digit per beat with its status flags.
// Depends on rcs_pkg.
interface rcs_out_if;
  import rcs_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] digit_char;
  logic              last_digit;
  logic              empty_value;
  logic              overflowed;
  logic              bad_digit;

  modport source (output valid, digit_char, last_digit, empty_value, overflowed,
                  bad_digit, input ready);
  modport sink   (input valid, digit_char, last_digit, empty_value, overflowed,
                  bad_digit, output ready);
endinterface

[rtl/rcs_cfg_if.sv]
// Configuration write channel: register index and write data per beat.
// Depends on rcs_pkg.
interface rcs_cfg_if;
  import rcs_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [REG_IDX_W-1:0] reg_index;
  logic [BASE_W-1:0]    wr_data;

  modport source (output valid, reg_index, wr_data, input ready);
  modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

[rtl/radix_conversion_stream.sv]
// Top level of the radix conversion stream: accumulator, bit-serial divider,
// digit memory and output register. Depends on rcs_pkg, the channel
// interfaces and radix_conversion_stream_defines.svh.
//
// Characters of a number arrive one per beat on din and fold into a 32-bit
// accumulator (value * source_base + digit) in the cycle they are accepted.
// The beat marked final_char starts the conversion: the value is divided by
// target_base with a restoring divider that retires one quotient bit per
// cycle, so each output digit takes one check and then one divide step per
// value bit, and the digits land least significant first in a 32-entry
// digit memory. They are then read back most significant first, each digit
// passing through a memory read, an output load and a beat on dout, which
// waits while dout holds ready low. A zero value gives a single beat flagged
// empty_value. The block takes no new character until the last digit beat
// has gone out. Configuration writes are taken in any cycle and should be
// made while idle.
module radix_conversion_stream (
  input logic       clk,
  input logic       rst,
  rcs_cfg_if.sink   cfg,
  rcs_in_if.sink    din,
  rcs_out_if.source dout
);
  import rcs_pkg::*;

  rcs_state_t state, state_next;

  logic [BASE_W-1:0]     src_base, tgt_base;
  logic [VALUE_BITS-1:0] acc;
  logic                  ovf_seen, bad_seen;

  logic [VALUE_BITS-1:0] quo;
  logic [BASE_W-1:0]     rem;
  logic [BIT_CNT_W-1:0]  bit_cnt;
  logic [CNT_W-1:0]      digit_count;
  logic [IDX_W-1:0]      idx;
  logic                  num_ovf, num_bad, trunc;

  logic [CHAR_W-1:0]     mem [MAX_DIGITS];
  logic [CHAR_W-1:0]     rd_data;

  logic [CHAR_W-1:0]     o_char;
  logic                  o_last, o_empty;

  // Accumulate datapath
  logic [BASE_W-1:0]       sb;
  logic [DIGIT_W-1:0]      dval;
  logic                    digit_ok;
  logic [VALUE_BITS+5:0]   prod;
  logic [VALUE_BITS+6:0]   mac;
  logic [VALUE_BITS-1:0]   acc_new;
  logic                    ovf_new, bad_new;
  logic                    in_acc, fin_acc;

  // Divide datapath
  logic [BASE_W-1:0]     tb;
  logic [BASE_W:0]       r_sh;
  logic                  q_bit;
  logic [BASE_W-1:0]     rem_step;
  logic [VALUE_BITS-1:0] quo_step;
  logic                  div_last, quo_zero, cnt_full, cnt_zero;

  assign sb       = clamp_base(src_base);
  assign dval     = decode_char(din.char_code);
  assign digit_ok = dval < DIGIT_W'(sb);
  assign prod     = (VALUE_BITS+BASE_W)'(acc) * (VALUE_BITS+BASE_W)'(sb);
  assign mac      = (VALUE_BITS+7)'(prod) + (VALUE_BITS+7)'(dval);
  assign acc_new  = digit_ok ? mac[VALUE_BITS-1:0] : acc;
  assign ovf_new  = ovf_seen | (digit_ok & (|mac[VALUE_BITS+6:VALUE_BITS]));
  assign bad_new  = bad_seen | ~digit_ok;

  assign din.ready = (state == ST_IDLE);
  assign in_acc    = din.valid && din.ready;
  assign fin_acc   = in_acc && din.final_char;

  assign tb       = clamp_base(tgt_base);
  assign r_sh     = {rem, quo[VALUE_BITS-1]};
  assign q_bit    = r_sh >= (BASE_W+1)'(tb);
  assign rem_step = q_bit ? BASE_W'(r_sh - (BASE_W+1)'(tb)) : r_sh[BASE_W-1:0];
  assign quo_step = {quo[VALUE_BITS-2:0], q_bit};
  assign div_last = bit_cnt == BIT_CNT_W'(VALUE_BITS - 1);
  assign quo_zero = quo == '0;
  assign cnt_full = digit_count == CNT_W'(MAX_DIGITS);
  assign cnt_zero = digit_count == '0;

  assign cfg.ready        = 1'b1;
  assign dout.valid       = (state == ST_SHOW);
  assign dout.digit_char  = o_char;
  assign dout.last_digit  = o_last;
  assign dout.empty_value = o_empty;
  assign dout.overflowed  = num_ovf | trunc;
  assign dout.bad_digit   = num_bad;

  // Hold the state register
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // Sequence: accumulate, divide digit by digit, then play digits back
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (fin_acc) state_next = ST_CHECK;
      ST_CHECK: begin
        if (quo_zero)      state_next = cnt_zero ? ST_SHOW : ST_READ;
        else if (cnt_full) state_next = ST_READ;
        else               state_next = ST_DIVIDE;
      end
      ST_DIVIDE: if (div_last) state_next = ST_CHECK;
      ST_READ:   state_next = ST_LOAD;
      ST_LOAD:   state_next = ST_SHOW;
      ST_SHOW: begin
        if (dout.ready) state_next = o_last ? ST_IDLE : ST_READ;
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  // Take configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      src_base <= SRC_BASE_RST;
      tgt_base <= TGT_BASE_RST;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.reg_index)
        REG_SOURCE_BASE: src_base <= cfg.wr_data;
        REG_TARGET_BASE: tgt_base <= cfg.wr_data;
        default: ;
      endcase
    end
  end

  // Fold characters into the accumulator; clear it when a number ends
  always_ff @(posedge clk) begin
    if (rst) begin
      acc      <= '0;
      ovf_seen <= 1'b0;
      bad_seen <= 1'b0;
    end else if (in_acc) begin
      if (din.final_char) begin
        acc      <= '0;
        ovf_seen <= 1'b0;
        bad_seen <= 1'b0;
      end else begin
        acc      <= acc_new;
        ovf_seen <= ovf_new;
        bad_seen <= bad_new;
      end
    end
  end

  // Conversion control: digit count, truncation mark, readback index
  always_ff @(posedge clk) begin
    if (rst) begin
      digit_count <= '0;
      trunc       <= 1'b0;
      idx         <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (fin_acc) begin
            digit_count <= '0;
            trunc       <= 1'b0;
          end
        end
        ST_CHECK: begin
          if (quo_zero) begin
            if (!cnt_zero) idx <= IDX_W'(digit_count - 1'b1);
          end else if (cnt_full) begin
            trunc <= 1'b1;
            idx   <= IDX_W'(MAX_DIGITS - 1);
          end
        end
        ST_DIVIDE: if (div_last) digit_count <= digit_count + 1'b1;
        ST_SHOW:   if (dout.ready && !o_last) idx <= idx - 1'b1;
        default: ;
      endcase
    end
  end

  // Divider registers and per-number flags
  always_ff @(posedge clk) begin
    if (fin_acc) begin
      quo     <= acc_new;
      num_ovf <= ovf_new;
      num_bad <= bad_new;
    end
    if (state == ST_CHECK) begin
      rem     <= '0;
      bit_cnt <= '0;
    end else if (state == ST_DIVIDE) begin
      rem     <= rem_step;
      quo     <= quo_step;
      bit_cnt <= bit_cnt + 1'b1;
    end
  end

  // Digit memory; written during divide, read every cycle, with the playback read never overlapping a write
  always_ff @(posedge clk) begin
    if (state == ST_DIVIDE && div_last)
      mem[digit_count[IDX_W-1:0]] <= encode_digit(rem_step);
    rd_data <= mem[idx];
  end

  // Load the output register
  always_ff @(posedge clk) begin
    if (state == ST_CHECK && quo_zero && cnt_zero) begin
      o_char  <= '0;
      o_last  <= 1'b1;
      o_empty <= 1'b1;
    end else if (state == ST_LOAD) begin
      o_char  <= rd_data;
      o_last  <= idx == '0;
      o_empty <= 1'b0;
    end
  end

`include "radix_conversion_stream_defines.svh"

  `RCS_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, digit_count <= CNT_W'(MAX_DIGITS))
  `RCS_ASSERT_NOW(a_empty_is_last, clk, rst, dout.valid && dout.empty_value, dout.last_digit)
  `RCS_ASSERT_NEXT(a_final_blocks_input, clk, rst, fin_acc, !din.ready)
  `RCS_ASSERT_NEXT(a_last_frees_input, clk, rst, dout.valid && dout.ready && dout.last_digit, din.ready)

endmodule
